### rtl/ste_pkg.sv
`default_nettype none
package ste_pkg;

    // Table size and field widths.
    localparam int STE_SLOTS = 128;
    localparam int KEY_W     = 16;
    localparam int PROTO_W   = 2;
    localparam int BYTE_W    = 8;
    localparam int TIME_W    = 32;
    localparam int IDX_W     = 7;
    localparam int COUNT_W   = 32;
    localparam int ACT_W     = 8;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 56;

    // Stored protocol codes.
    localparam logic [PROTO_W-1:0] PROTO_MQTT = 2'd1;
    localparam logic [PROTO_W-1:0] PROTO_COAP = 2'd2;

    // MQTT packet types, taken from the upper nibble of the first byte.
    localparam logic [3:0] MQTT_TYPE_CONN  = 4'd1;
    localparam logic [3:0] MQTT_PINGREQ    = 4'd12;
    localparam logic [3:0] MQTT_DISCONNECT = 4'd14;

    // CoAP request codes that get an acknowledgment.
    localparam logic [BYTE_W-1:0] COAP_CODE_MIN = 8'd1;
    localparam logic [BYTE_W-1:0] COAP_CODE_MAX = 8'd31;

    typedef enum logic [1:0] {
        MODE_CREATE  = 2'd0,
        MODE_LOOKUP  = 2'd1,
        MODE_REMOVE  = 2'd2,
        MODE_MESSAGE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_CONNECTED     = 3'd0,
        PH_AUTH          = 3'd1,
        PH_ACTIVE        = 3'd2,
        PH_DISCONNECTING = 3'd3,
        PH_CLOSED        = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        RP_NONE     = 2'd0,
        RP_CONNACK  = 2'd1,
        RP_PINGRESP = 2'd2,
        RP_COAP_ACK = 2'd3
    } reply_t;

    // Search token that walks the row of slot cells, one cell per cycle.
    // The request fields ride along unchanged; the result fields are filled
    // in by the cell that serves the request, after which done is set.
    typedef struct packed {
        logic                vld;
        logic                done;
        mode_t               mode;
        logic [KEY_W-1:0]    key;
        logic [PROTO_W-1:0]  proto;
        logic [BYTE_W-1:0]   b0;
        logic [BYTE_W-1:0]   b1;
        logic [TIME_W-1:0]   now;
        logic [IDX_W-1:0]    idx;
        phase_t              phase;
        logic [PROTO_W-1:0]  r_proto;
        logic [COUNT_W-1:0]  count;
        reply_t              reply;
    } tok_t;

endpackage
`default_nettype wire

### rtl/ste_cell.sv
`default_nettype none
module ste_cell
    import ste_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire tok_t tok_i,
    output tok_t      tok_o
);

    logic               valid_reg, valid_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [PROTO_W-1:0] proto_reg, proto_next;
    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TIME_W-1:0]  last_seen_reg, last_seen_next;
    logic [TIME_W-1:0]  born_reg, born_next;
    logic               vld_reg;
    tok_t               tok_reg, tok_next;

    logic               searching;
    logic               free_hit;
    logic               key_hit;
    phase_t             msg_phase;
    reply_t             msg_reply;
    logic [COUNT_W-1:0] count_inc;

    always_comb begin
        searching = tok_i.vld && !tok_i.done;
        free_hit  = searching && (tok_i.mode == MODE_CREATE) && !valid_reg;
        key_hit   = searching && (tok_i.mode != MODE_CREATE) && valid_reg
                    && (key_reg == tok_i.key);
        count_inc = count_reg + COUNT_W'(1);

        // Protocol handling of one received message.
        msg_phase = phase_reg;
        msg_reply = RP_NONE;
        if (proto_reg == PROTO_MQTT) begin
            case (tok_i.b0[7:4])
                MQTT_TYPE_CONN: begin
                    msg_phase = PH_AUTH;
                    msg_reply = RP_CONNACK;
                end
                MQTT_PINGREQ: begin
                    msg_reply = RP_PINGRESP;
                end
                MQTT_DISCONNECT: begin
                    msg_phase = PH_DISCONNECTING;
                end
                default: begin
                    msg_phase = phase_reg;
                end
            endcase
        end else if (proto_reg == PROTO_COAP) begin
            if ((tok_i.b1 >= COAP_CODE_MIN) && (tok_i.b1 <= COAP_CODE_MAX)) begin
                msg_reply = RP_COAP_ACK;
            end
        end

        valid_next     = valid_reg;
        key_next       = key_reg;
        proto_next     = proto_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        last_seen_next = last_seen_reg;
        born_next      = born_reg;
        tok_next       = tok_i;

        if (free_hit) begin
            valid_next       = 1'b1;
            key_next         = tok_i.key;
            proto_next       = tok_i.proto;
            phase_next       = PH_CONNECTED;
            count_next       = '0;
            last_seen_next   = tok_i.now;
            born_next        = tok_i.now;
            tok_next.done    = 1'b1;
            tok_next.idx     = IDX_W'(CELL_IDX);
            tok_next.phase   = PH_CONNECTED;
            tok_next.r_proto = tok_i.proto;
            tok_next.count   = '0;
            tok_next.reply   = RP_NONE;
        end else if (key_hit) begin
            tok_next.done    = 1'b1;
            tok_next.idx     = IDX_W'(CELL_IDX);
            tok_next.r_proto = proto_reg;
            tok_next.phase   = phase_reg;
            tok_next.count   = count_reg;
            tok_next.reply   = RP_NONE;
            case (tok_i.mode)
                MODE_REMOVE: begin
                    valid_next = 1'b0;
                end
                MODE_MESSAGE: begin
                    phase_next     = msg_phase;
                    count_next     = count_inc;
                    last_seen_next = tok_i.now;
                    tok_next.phase = msg_phase;
                    tok_next.count = count_inc;
                    tok_next.reply = msg_reply;
                end
                default: begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            vld_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            vld_reg   <= tok_i.vld;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        proto_reg     <= proto_next;
        phase_reg     <= phase_next;
        count_reg     <= count_next;
        last_seen_reg <= last_seen_next;
        born_reg      <= born_next;
        tok_reg       <= tok_next;
    end

    always_comb begin
        tok_o     = tok_reg;
        tok_o.vld = vld_reg;
    end

endmodule
`default_nettype wire

### rtl/session_table_engine.sv
// Path: the search token is registered in each slot cell in turn, and the
// result item is registered in the output stage before it is offered on m_tvalid.
// Throughput: a new item is not taken while a search is running; the search token
// visits one slot cell per cycle and the next item enters after it leaves the last cell.
// Reset: synchronous, active low; all slots free, active count zero, no item
// in flight. Slot payload is written on create and needs no clearing.
`default_nettype none
module session_table_engine
    import ste_pkg::*;
#(
    parameter int SLOTS = STE_SLOTS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata, from bit 0 up: conn_key[15:0], proto_in[17:16],
    // hdr_byte[25:18], second_byte[33:26], now_time[65:34], zero fill.
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: mode[1:0] (0 create, 1 lookup, 2 remove, 3 message).
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata, from bit 0 up: status[1:0], slot_index[8:2], sess_state[11:9],
    // proto_out[13:12], msg_total[45:14], reply_kind[47:46],
    // active_total[55:48].
    output logic [M_TDATA_W-1:0]       m_tdata
);

    localparam int LIVE_W = $clog2(SLOTS + 1);

    // The token chain: entry 0 is the request being accepted, entry i+1 is
    // what cell i hands on, and the last entry is the finished search.
    tok_t chain [0:SLOTS];

    logic                 busy_reg, busy_next;
    logic [LIVE_W-1:0]    live_reg, live_next;
    logic                 m_vld_reg, m_vld_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                 skid_vld_reg, skid_vld_next;
    logic [M_TDATA_W-1:0] skid_data_reg, skid_data_next;

    logic                 accept;
    logic                 exit_vld;
    logic                 out_free;
    status_t              exit_status;
    logic [M_TDATA_W-1:0] exit_data;
    logic [SLOTS-1:0]     tok_vld_vec;

    // A new item enters only when no search is running and the skid stage
    // is empty, so the finished result always has a place to go.
    assign s_tready = !busy_reg && !skid_vld_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        chain[0]         = '0;
        chain[0].vld     = accept;
        chain[0].done    = 1'b0;
        chain[0].mode    = mode_t'(s_tuser);
        chain[0].key     = s_tdata[15:0];
        chain[0].proto   = s_tdata[17:16];
        chain[0].b0      = s_tdata[25:18];
        chain[0].b1      = s_tdata[33:26];
        chain[0].now     = s_tdata[65:34];
        chain[0].phase   = PH_CONNECTED;
        chain[0].reply   = RP_NONE;
    end

    // One cell per slot; the lowest slot sees the token first, which gives
    // the lowest free or lowest matching slot.
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        ste_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_i   (chain[i]),
            .tok_o   (chain[i+1])
        );
        assign tok_vld_vec[i] = chain[i+1].vld;
    end

    assign exit_vld = chain[SLOTS].vld;
    assign out_free = !m_vld_reg || m_tready;

    // Finishing the item: a token that no cell served reports full for a
    // create and not found otherwise, with its result fields still zero.
    always_comb begin
        live_next = live_reg;
        if (exit_vld && chain[SLOTS].done) begin
            if (chain[SLOTS].mode == MODE_CREATE) begin
                live_next = live_reg + LIVE_W'(1);
            end else if ((chain[SLOTS].mode == MODE_REMOVE) && (live_reg != '0)) begin
                live_next = live_reg - LIVE_W'(1);
            end
        end

        if (chain[SLOTS].done) begin
            exit_status = ST_OK;
        end else if (chain[SLOTS].mode == MODE_CREATE) begin
            exit_status = ST_FULL;
        end else begin
            exit_status = ST_MISSING;
        end

        exit_data = {ACT_W'(live_next),
                     chain[SLOTS].reply,
                     chain[SLOTS].count,
                     chain[SLOTS].r_proto,
                     chain[SLOTS].phase,
                     chain[SLOTS].idx,
                     exit_status};
    end

    // Output register with a one-entry skid stage behind it.
    always_comb begin
        busy_next      = busy_reg;
        m_vld_next     = m_vld_reg;
        m_data_next    = m_data_reg;
        skid_vld_next  = skid_vld_reg;
        skid_data_next = skid_data_reg;

        if (accept) begin
            busy_next = 1'b1;
        end else if (exit_vld) begin
            busy_next = 1'b0;
        end

        if (out_free) begin
            if (skid_vld_reg) begin
                m_vld_next    = 1'b1;
                m_data_next   = skid_data_reg;
                skid_vld_next = 1'b0;
            end else if (exit_vld) begin
                m_vld_next  = 1'b1;
                m_data_next = exit_data;
            end else begin
                m_vld_next = 1'b0;
            end
        end else if (exit_vld) begin
            skid_vld_next  = 1'b1;
            skid_data_next = exit_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            live_reg     <= '0;
            m_vld_reg    <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            live_reg     <= live_next;
            m_vld_reg    <= m_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

    // At most one search token is ever in the row of cells.
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_vld_vec))
        else $error("more than one search token in the slot chain");

    // A token only leaves the chain while a search is marked as running.
    a_exit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        exit_vld |-> busy_reg)
        else $error("search token left the chain with no search running");

    // The active count never exceeds the number of slots.
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= LIVE_W'(SLOTS))
        else $error("active session count above table size");

    // A failed item carries zero slot fields.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_vld_reg && (m_data_reg[1:0] != ST_OK))
        |-> (m_data_reg[47:2] == '0))
        else $error("failed result carries nonzero slot fields");

endmodule
`default_nettype wire
